// ===== design/lightweight_feistel_block_cipher_defines.svh =====
// Assertion macros shared by the cipher modules.
`ifndef LIGHTWEIGHT_FEISTEL_BLOCK_CIPHER_DEFINES_SVH
`define LIGHTWEIGHT_FEISTEL_BLOCK_CIPHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lfbc_pkg.sv =====
`timescale 1ns / 1ps

package lfbc_pkg;

	localparam int unsigned KEY_WIDTH = 80;
	localparam int unsigned HALF_WIDTH = 32;
	localparam int unsigned KEY_HIGH_WIDTH = 16;
	localparam int unsigned KEY_LOW_WIDTH = 64;
	localparam int unsigned CFG_DATA_WIDTH = 64;
	localparam int unsigned CFG_INDEX_WIDTH = 1;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KEY_HIGH = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KEY_LOW = 1'b1;

	localparam logic ACTION_ENCRYPT = 1'b0;
	localparam logic ACTION_DECRYPT = 1'b1;

	localparam int unsigned SBOX_KEY_TOP = 9;
	localparam int unsigned SBOX_KEY_NEXT = 8;

	typedef logic [HALF_WIDTH-1:0] half_t;
	typedef logic [KEY_WIDTH-1:0] key_t;

	localparam logic [3:0] SBOX [0:9][0:15] = '{
		'{4'd14, 4'd9, 4'd15, 4'd0, 4'd13, 4'd4, 4'd10, 4'd11,
		  4'd1, 4'd2, 4'd8, 4'd3, 4'd7, 4'd6, 4'd12, 4'd5},
		'{4'd4, 4'd11, 4'd14, 4'd9, 4'd15, 4'd13, 4'd0, 4'd10,
		  4'd7, 4'd12, 4'd5, 4'd6, 4'd2, 4'd8, 4'd1, 4'd3},
		'{4'd1, 4'd14, 4'd7, 4'd12, 4'd15, 4'd13, 4'd0, 4'd6,
		  4'd11, 4'd5, 4'd9, 4'd3, 4'd2, 4'd4, 4'd8, 4'd10},
		'{4'd7, 4'd6, 4'd8, 4'd11, 4'd0, 4'd15, 4'd3, 4'd14,
		  4'd9, 4'd10, 4'd12, 4'd13, 4'd5, 4'd2, 4'd4, 4'd1},
		'{4'd14, 4'd5, 4'd15, 4'd0, 4'd7, 4'd2, 4'd12, 4'd13,
		  4'd1, 4'd8, 4'd4, 4'd9, 4'd11, 4'd10, 4'd6, 4'd3},
		'{4'd2, 4'd13, 4'd11, 4'd12, 4'd15, 4'd14, 4'd0, 4'd9,
		  4'd7, 4'd10, 4'd6, 4'd3, 4'd1, 4'd8, 4'd4, 4'd5},
		'{4'd11, 4'd9, 4'd4, 4'd14, 4'd0, 4'd15, 4'd10, 4'd13,
		  4'd6, 4'd12, 4'd5, 4'd7, 4'd3, 4'd8, 4'd1, 4'd2},
		'{4'd13, 4'd10, 4'd15, 4'd0, 4'd14, 4'd4, 4'd9, 4'd11,
		  4'd2, 4'd1, 4'd8, 4'd3, 4'd7, 4'd5, 4'd12, 4'd6},
		'{4'd8, 4'd7, 4'd14, 4'd5, 4'd15, 4'd13, 4'd0, 4'd6,
		  4'd11, 4'd12, 4'd9, 4'd10, 4'd2, 4'd4, 4'd1, 4'd3},
		'{4'd11, 4'd5, 4'd15, 4'd0, 4'd7, 4'd2, 4'd9, 4'd13,
		  4'd4, 4'd8, 4'd1, 4'd12, 4'd14, 4'd10, 4'd3, 4'd6}
	};

	// Output nibble j, counted from the top, takes input nibble PERM[j] from the top.
	localparam int unsigned PERM [0:7] = '{1, 3, 0, 2, 5, 7, 4, 6};

endpackage

// ===== design/lfbc_round.sv =====
`timescale 1ns / 1ps

module lfbc_round (
	input  lfbc_pkg::half_t left,
	input  lfbc_pkg::half_t right,
	input  lfbc_pkg::half_t round_key,
	input  logic            decrypt,
	output lfbc_pkg::half_t new_right
);
	import lfbc_pkg::*;

	half_t mixed;
	half_t subst;
	half_t permuted;

	always_comb begin
		mixed = left ^ round_key;
		subst = '0;
		permuted = '0;
		for (int i = 0; i < 8; i++) begin
			subst[4*i +: 4] = SBOX[i][mixed[4*i +: 4]];
		end
		for (int j = 0; j < 8; j++) begin
			permuted[28 - 4*j +: 4] = subst[28 - 4*PERM[j] +: 4];
		end
	end

	always_comb begin
		if (decrypt == ACTION_DECRYPT) begin
			new_right = {right[7:0] ^ permuted[7:0], right[31:8] ^ permuted[31:8]};
		end else begin
			new_right = {right[23:0], right[31:24]} ^ permuted;
		end
	end

endmodule

// ===== design/lfbc_key_sched.sv =====
`timescale 1ns / 1ps
`include "lightweight_feistel_block_cipher_defines.svh"

module lfbc_key_sched #(
	parameter int unsigned ROUND_COUNT = 32,
	parameter int unsigned AW = $clog2(ROUND_COUNT)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [lfbc_pkg::CFG_INDEX_WIDTH-1:0]   wr_index,
	input  logic [lfbc_pkg::CFG_DATA_WIDTH-1:0]    wr_data,
	input  logic [AW-1:0]                          rd_addr,
	output lfbc_pkg::half_t                        rd_key,
	output logic                                   expanding
);
	import lfbc_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(ROUND_COUNT - 1);

	logic [KEY_HIGH_WIDTH-1:0] key_high_q;
	logic [KEY_LOW_WIDTH-1:0]  key_low_q;
	logic [KEY_HIGH_WIDTH-1:0] key_high_next;
	logic [KEY_LOW_WIDTH-1:0]  key_low_next;
	key_t                      work_key_q;
	key_t                      work_key_next;
	logic [AW-1:0]             cnt_q;
	logic                      active_q;
	logic [4:0]                update_num;
	half_t                     round_keys [ROUND_COUNT];
	half_t                     rd_key_q;

	always_comb begin
		key_high_next = key_high_q;
		key_low_next = key_low_q;
		if (wr_en) begin
			case (wr_index)
				REG_KEY_HIGH: key_high_next = wr_data[KEY_HIGH_WIDTH-1:0];
				REG_KEY_LOW:  key_low_next = wr_data;
				default:      key_low_next = key_low_q;
			endcase
		end
	end

	// One key update: rotate left by 29, S-boxes on the top two nibbles, XOR the count plus one.
	always_comb begin
		update_num = 5'(cnt_q) + 5'd1;
		work_key_next = {work_key_q[50:0], work_key_q[79:51]};
		work_key_next[79:76] = SBOX[SBOX_KEY_TOP][work_key_next[79:76]];
		work_key_next[75:72] = SBOX[SBOX_KEY_NEXT][work_key_next[75:72]];
		work_key_next[50:46] = work_key_next[50:46] ^ update_num;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			work_key_q <= '0;
			cnt_q <= '0;
			active_q <= 1'b1;
		end else begin
			key_high_q <= key_high_next;
			key_low_q <= key_low_next;
			if (wr_en) begin
				work_key_q <= {key_high_next, key_low_next};
				cnt_q <= '0;
				active_q <= 1'b1;
			end else if (active_q) begin
				work_key_q <= work_key_next;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active_q && !wr_en) begin
			round_keys[cnt_q] <= work_key_q[79:48];
		end
		rd_key_q <= round_keys[rd_addr];
	end

	assign rd_key = rd_key_q;
	assign expanding = active_q;

	`LFBC_ASSERT_NEXT(a_write_starts_expand, clk, arst_n, wr_en, active_q && cnt_q == '0, "key write did not restart expansion")
	`LFBC_ASSERT_NEXT(a_expand_runs_through, clk, arst_n, active_q && cnt_q != LAST, active_q, "expansion stopped early")
	`LFBC_ASSERT_NEXT(a_expand_ends, clk, arst_n, active_q && cnt_q == LAST && !wr_en, !active_q, "expansion did not end after the last key")

endmodule

// ===== design/lightweight_feistel_block_cipher.sv =====
`timescale 1ns / 1ps
`include "lightweight_feistel_block_cipher_defines.svh"

// 64-bit block cipher with an 80-bit key, one Feistel round per clock cycle.
// The key is written through wr_en, wr_index and wr_data: index 0 holds key
// bits 79..64, index 1 holds key bits 63..0. Every key write, and reset,
// starts an expansion that fills the round-key memory, one round key per
// cycle; busy is high while it runs.
// A word is taken at a rising edge where start is high and busy is low;
// action selects encryption (0) or decryption (1). The block then reads
// the first round key in a fetch state and then runs the rounds in a round
// state, all through a single round unit fed by the registered memory read.
// The result appears on out_left and out_right with done high for exactly
// one cycle. busy is low in that cycle unless a key write has started an
// expansion, so the next word can be taken at the edge that ends it; a new
// word is never accepted while one is still in its rounds.
// The receiver cannot stall; the result must be captured while done is high.
// Reset clears the key to zero and then expands it; busy stays high after
// reset is released until that expansion ends.
module lightweight_feistel_block_cipher #(
	parameter int unsigned ROUND_COUNT = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	output logic                                 done,
	input  logic                                 action,
	input  lfbc_pkg::half_t                      block_left,
	input  lfbc_pkg::half_t                      block_right,
	output lfbc_pkg::half_t                      out_left,
	output lfbc_pkg::half_t                      out_right,
	input  logic                                 wr_en,
	input  logic [lfbc_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
	input  logic [lfbc_pkg::CFG_DATA_WIDTH-1:0]  wr_data
);
	import lfbc_pkg::*;

	localparam int unsigned AW = $clog2(ROUND_COUNT);
	localparam logic [AW-1:0] LAST = AW'(ROUND_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_ROUND
	} state_t;

	state_t        state_q;
	half_t         left_q;
	half_t         right_q;
	logic          decrypt_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] round_q;
	logic [AW-1:0] next_addr;
	half_t         out_left_q;
	half_t         out_right_q;
	logic          done_q;
	half_t         round_key;
	half_t         new_right;
	logic          expanding;

	lfbc_key_sched #(
		.ROUND_COUNT(ROUND_COUNT),
		.AW(AW)
	) u_key_sched (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.rd_addr(addr_q),
		.rd_key(round_key),
		.expanding(expanding)
	);

	lfbc_round u_round (
		.left(left_q),
		.right(right_q),
		.round_key(round_key),
		.decrypt(decrypt_q),
		.new_right(new_right)
	);

	assign next_addr = (decrypt_q == ACTION_DECRYPT) ? addr_q - 1'b1 : addr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q <= '0;
			right_q <= '0;
			decrypt_q <= ACTION_ENCRYPT;
			addr_q <= '0;
			round_q <= '0;
			out_left_q <= '0;
			out_right_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && !expanding) begin
						left_q <= block_left;
						right_q <= block_right;
						decrypt_q <= action;
						addr_q <= (action == ACTION_DECRYPT) ? LAST : '0;
						round_q <= '0;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					addr_q <= next_addr;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (round_q == LAST) begin
						out_left_q <= left_q;
						out_right_q <= new_right;
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						left_q <= new_right;
						right_q <= left_q;
						round_q <= round_q + 1'b1;
						addr_q <= next_addr;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE) || expanding;
	assign done = done_q;
	assign out_left = out_left_q;
	assign out_right = out_right_q;

	`LFBC_ASSERT_NEXT(a_start_fetches, clk, arst_n, start && !busy, state_q == ST_FETCH, "accepted word did not enter the fetch cycle")
	`LFBC_ASSERT_NEXT(a_last_round_done, clk, arst_n, state_q == ST_ROUND && round_q == LAST, done_q && state_q == ST_IDLE, "last round did not deliver a result")
	`LFBC_ASSERT_NOW(a_done_after_round, clk, arst_n, done_q, $past(state_q == ST_ROUND), "result strobe without a finished round")
	`LFBC_ASSERT_NOW(a_no_expand_in_work, clk, arst_n, state_q == ST_ROUND, !expanding, "round keys changed during a word")

endmodule
